// ----- rtl/core/iop_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval overlap pair emitter package
// Sizes, the queued job type and shared constants of the pair emitter.
// ----------------------------------------------------------------------------
package iop_pkg;

  localparam int ACTIVE_DEPTH = 32;
  localparam int COORD_BITS   = 16;
  localparam int INDEX_BITS   = 16;
  localparam int SLOT_BITS    = $clog2(ACTIVE_DEPTH);

  // Job queue between the numbering front and the sweep engine.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                  restart;
    logic [COORD_BITS-1:0] start_pos;
    logic [COORD_BITS-1:0] end_pos;
    logic [INDEX_BITS-1:0] vertex;
  } iop_job_t;

endpackage

// ----- rtl/core/iop_if.sv -----
// ----------------------------------------------------------------------------
// Interval overlap pair emitter channels
// Valid/ready channels for intervals in and vertex pairs out.
// ----------------------------------------------------------------------------
interface iop_in_if
  import iop_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  restart;
  logic [COORD_BITS-1:0] start_pos;
  logic [COORD_BITS-1:0] end_pos;

  modport source (output valid, restart, start_pos, end_pos, input ready);
  modport sink (input valid, restart, start_pos, end_pos, output ready);
endinterface

interface iop_out_if
  import iop_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] first_vertex;
  logic [INDEX_BITS-1:0] second_vertex;
  logic                  set_overflow;
  logic                  last_pair;

  modport source (output valid, first_vertex, second_vertex, set_overflow, last_pair,
                  input ready);
  modport sink (input valid, first_vertex, second_vertex, set_overflow, last_pair,
                output ready);
endinterface

// ----- rtl/core/interval_overlap_pair_emitter.sv -----
// ----------------------------------------------------------------------------
// Interval overlap pair emitter
// Sweep-line join that emits every overlapping pair of sorted intervals.
// ----------------------------------------------------------------------------
// Intervals arrive on in_i, sorted by start, as unsigned Q8.8 start and end,
// one per item; each takes the next vertex number, and restart set on an item
// clears the active set and makes that item vertex zero. For every stored
// interval whose end lies beyond the new start, out_o carries one item with
// the stored and the new vertex, in ascending stored vertex, the final one
// marked by last_pair. An item with no overlap produces nothing.
// The front numbers intervals and feeds a two-deep queue; the sweep engine
// takes a job from it only once every pair of the previous job is emitted,
// then emits that job's pairs one at a time. The first pair reaches out_o
// through the queue, the pending set and the output register.
// While out_o is stalled the output register holds its pair and the engine
// waits; the queue keeps taking intervals until both of its places are full.
// Reset empties the active set, the queue and the output, and restarts the
// vertex numbering at zero.
module interval_overlap_pair_emitter
  import iop_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  iop_in_if.sink    in_i,
  iop_out_if.source out_o
);

  logic     push_valid, push_ready;
  iop_job_t push_data;
  logic     job_valid, job_ready;
  iop_job_t job;

  iop_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  iop_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (job_valid),
    .pop_data_o   (job),
    .pop_ready_i  (job_ready)
  );

  iop_sweep u_sweep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/core/iop_queue.sv -----
// ----------------------------------------------------------------------------
// Interval overlap job queue
// Short register queue that lets the front and the sweep engine stall apart.
// ----------------------------------------------------------------------------
module iop_queue
  import iop_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  iop_job_t push_data_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output iop_job_t pop_data_o,
  input  logic     pop_ready_i
);

  iop_job_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/iop_front.sv -----
// ----------------------------------------------------------------------------
// Interval overlap front
// Accepts intervals, handles restart and numbers each one with its vertex.
// ----------------------------------------------------------------------------
module iop_front
  import iop_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  iop_in_if.sink   in_i,
  output logic     push_valid_o,
  output iop_job_t push_data_o,
  input  logic     push_ready_i
);

  logic [INDEX_BITS-1:0] next_vertex_q, next_vertex_d;
  logic [INDEX_BITS-1:0] vertex;
  logic                  accept;

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && push_ready_i;
  assign push_valid_o = in_i.valid;

  // A restart item becomes vertex zero itself.
  assign vertex        = in_i.restart ? '0 : next_vertex_q;
  assign next_vertex_d = accept ? vertex + 1'b1 : next_vertex_q;

  always_comb begin
    push_data_o.restart   = in_i.restart;
    push_data_o.start_pos = in_i.start_pos;
    push_data_o.end_pos   = in_i.end_pos;
    push_data_o.vertex    = vertex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vertex_q <= '0;
    end else begin
      next_vertex_q <= next_vertex_d;
    end
  end

endmodule

// ----- rtl/core/iop_sweep.sv -----
// ----------------------------------------------------------------------------
// Interval overlap sweep engine
// Holds the active set, retires and stores intervals, and emits the pairs.
// ----------------------------------------------------------------------------
module iop_sweep
  import iop_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  iop_job_t job_i,
  output logic     job_ready_o,
  iop_out_if.source out_o
);

  logic [ACTIVE_DEPTH-1:0] valid_q, valid_d;
  logic [COORD_BITS-1:0]   end_q   [ACTIVE_DEPTH];
  logic [INDEX_BITS-1:0]   index_q [ACTIVE_DEPTH];
  // before_q[i][j] is set when slot i is emitted ahead of slot j.
  logic [ACTIVE_DEPTH-1:0] before_q [ACTIVE_DEPTH];
  logic [ACTIVE_DEPTH-1:0] pend_q, pend_d;
  logic [INDEX_BITS-1:0]   cur_vertex_q;
  logic                    ovf_q;

  logic                    out_valid_q, out_valid_d;
  logic [INDEX_BITS-1:0]   out_first_q;
  logic [INDEX_BITS-1:0]   out_second_q;
  logic                    out_ovf_q;
  logic                    out_last_q;

  logic                    pop;
  logic [ACTIVE_DEPTH-1:0] keep;
  logic [SLOT_BITS-1:0]    free_slot;
  logic                    free_found;
  logic                    overflow;
  logic [ACTIVE_DEPTH-1:0] new_before;
  logic                    emit;
  logic [ACTIVE_DEPTH-1:0] sel;
  logic [INDEX_BITS-1:0]   sel_index;
  logic [ACTIVE_DEPTH-1:0] pend_rest;

  // A new job is taken only once every pair of the previous one is out.
  assign job_ready_o = (pend_q == '0);
  assign pop         = job_valid_i && job_ready_o;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      keep[i] = valid_q[i] && !job_i.restart && (end_q[i] > job_i.start_pos);
      if (!keep[i] && !free_found) begin
        free_slot  = SLOT_BITS'(i);
        free_found = 1'b1;
      end
    end
    overflow = !free_found;
  end

  // Order of the new entry against every stored one; equal indices fall back
  // on slot order.
  always_comb begin
    for (int j = 0; j < ACTIVE_DEPTH; j++) begin
      new_before[j] = (job_i.vertex < index_q[j]) ||
                      ((job_i.vertex == index_q[j]) && (free_slot < SLOT_BITS'(j)));
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop) begin
      valid_d = keep;
      if (!overflow) begin
        valid_d[free_slot] = 1'b1;
      end
    end
  end

  // The pending entry that comes ahead of every other pending entry.
  always_comb begin
    sel_index = '0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      sel[i] = pend_q[i];
      for (int j = 0; j < ACTIVE_DEPTH; j++) begin
        if (j != i && pend_q[j] && !before_q[i][j]) begin
          sel[i] = 1'b0;
        end
      end
      sel_index = sel_index | (index_q[i] & {INDEX_BITS{sel[i]}});
    end
  end

  assign emit      = (pend_q != '0) && (!out_valid_q || out_o.ready);
  assign pend_rest = pend_q & ~sel;

  always_comb begin
    pend_d = pend_q;
    if (pop) begin
      pend_d = keep;
    end else if (emit) begin
      pend_d = pend_rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_vertex_q <= job_i.vertex;
      ovf_q        <= overflow;
      if (!overflow) begin
        end_q[free_slot]    <= job_i.end_pos;
        index_q[free_slot]  <= job_i.vertex;
        before_q[free_slot] <= new_before;
        for (int j = 0; j < ACTIVE_DEPTH; j++) begin
          if (SLOT_BITS'(j) != free_slot) begin
            before_q[j][free_slot] <= !new_before[j];
          end
        end
      end
    end
    if (emit) begin
      out_first_q  <= sel_index;
      out_second_q <= cur_vertex_q;
      out_ovf_q    <= ovf_q;
      out_last_q   <= (pend_rest == '0);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.first_vertex  = out_first_q;
  assign out_o.second_vertex = out_second_q;
  assign out_o.set_overflow  = out_ovf_q;
  assign out_o.last_pair     = out_last_q;

  a_sel_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> $onehot(sel))
    else $error("pair selection is not a single entry");

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~valid_q) == '0)
    else $error("pending pair refers to an empty slot");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (pend_rest == '0)) |=> (pend_q == '0) && out_o.last_pair)
    else $error("final pair of an item is not marked");

  a_full_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && overflow) |=> (valid_q == '1) && (pend_q == '1))
    else $error("full set without every entry overlapping");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval overlap pair emitter regression
// Drives sorted and unsorted intervals into the pair emitter, predicts every
// overlapping vertex pair from a sweep-line model of the active set, and
// checks each emitted pair in order, under random source and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import iop_pkg::*;

  typedef struct packed {
    logic [INDEX_BITS-1:0] first_v;
    logic [INDEX_BITS-1:0] second_v;
    logic                  ovf;
    logic                  last;
  } vertex_pair_t;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  logic clk_i;
  logic rst_ni;

  iop_in_if  in_ch ();
  iop_out_if out_ch ();

  interval_overlap_pair_emitter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Sweep-line state of the predictor.
  logic [COORD_BITS-1:0] span_end  [ACTIVE_DEPTH];
  logic [INDEX_BITS-1:0] span_id   [ACTIVE_DEPTH];
  logic                  span_live [ACTIVE_DEPTH];
  logic [INDEX_BITS-1:0] vertex_count;

  vertex_pair_t pair_fifo[$];
  int           errors;
  int           src_idle_pct;
  int           snk_idle_pct;
  int           hold_req;
  int           hold_left;
  int           quiet_cycles;

  always #2 clk_i = ~clk_i;

  task automatic clear_spans();
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      span_end[i]  = '0;
      span_id[i]   = '0;
      span_live[i] = 1'b0;
    end
    vertex_count = '0;
  endtask

  // Retires finished spans, queues one pair per surviving span in ascending
  // vertex order, then stores the new span in the lowest free slot.
  task automatic predict_overlaps(input logic rs, input logic [COORD_BITS-1:0] s,
                                  input logic [COORD_BITS-1:0] e);
    logic                  hit [ACTIVE_DEPTH];
    logic [INDEX_BITS-1:0] vid;
    int                    hits;
    int                    free_slot;
    int                    best;
    logic                  full;
    vertex_pair_t          p;
    if (rs) clear_spans();
    vid          = vertex_count;
    vertex_count = vertex_count + 1'b1;
    hits         = 0;
    free_slot    = -1;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      hit[i] = 1'b0;
      if (span_live[i]) begin
        if (span_end[i] > s) begin
          hit[i] = 1'b1;
          hits++;
        end else begin
          span_live[i] = 1'b0;
        end
      end
      if (!span_live[i] && free_slot < 0) free_slot = i;
    end
    full = (free_slot < 0);
    for (int k = 0; k < hits; k++) begin
      best = -1;
      for (int i = 0; i < ACTIVE_DEPTH; i++) begin
        if (hit[i] && (best < 0 || span_id[i] < span_id[best])) best = i;
      end
      hit[best]  = 1'b0;
      p.first_v  = span_id[best];
      p.second_v = vid;
      p.ovf      = full;
      p.last     = (k == hits - 1);
      pair_fifo.push_back(p);
    end
    if (!full) begin
      span_live[free_slot] = 1'b1;
      span_end[free_slot]  = e;
      span_id[free_slot]   = vid;
    end
  endtask

  task automatic compare_field(input string name, input logic [INDEX_BITS-1:0] exp_v,
                               input logic [INDEX_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Accepted intervals feed the predictor; accepted pairs are checked.
  always @(posedge clk_i) begin
    vertex_pair_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        predict_overlaps(in_ch.restart, in_ch.start_pos, in_ch.end_pos);
      if (out_ch.valid && out_ch.ready) begin
        if (pair_fifo.size() == 0) begin
          $display("%0t: unexpected pair, actual %0d-%0d ovf %0b last %0b", $time,
                   out_ch.first_vertex, out_ch.second_vertex, out_ch.set_overflow,
                   out_ch.last_pair);
          errors++;
        end else begin
          want = pair_fifo.pop_front();
          compare_field("first_vertex", want.first_v, out_ch.first_vertex);
          compare_field("second_vertex", want.second_v, out_ch.second_vertex);
          compare_field("set_overflow", want.ovf, out_ch.set_overflow);
          compare_field("last_pair", want.last, out_ch.last_pair);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("interval_overlap_pair_emitter regression: fail");
        $finish;
      end
    end
  end

  // Pair sink: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offers one item from a falling edge, after any random source stall, and returns once it is taken.
  task automatic send_interval(input logic rs, input logic [COORD_BITS-1:0] s,
                               input logic [COORD_BITS-1:0] e);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.restart   <= rs;
    in_ch.start_pos <= s;
    in_ch.end_pos   <= e;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic test_directed();
    send_interval(1'b1, 16'h0000, 16'h0000);
    send_interval(1'b0, 16'h0000, 16'h0100);
    send_interval(1'b0, 16'h0000, COORD_MAX);
    send_interval(1'b0, 16'h0080, 16'h0080);
    // An end equal to the new start retires the entry.
    send_interval(1'b0, 16'h0100, 16'h0200);
    // Inverted interval, then a start that goes backwards.
    send_interval(1'b0, 16'h0180, 16'h0010);
    send_interval(1'b0, 16'h0050, 16'h0060);
    send_interval(1'b0, 16'h0050, 16'hAAAA);
    send_interval(1'b0, 16'h5555, 16'h5555);
    send_interval(1'b0, COORD_MAX, COORD_MAX);
    send_interval(1'b0, COORD_MAX, COORD_MAX);
    // Restart while entries are still live.
    send_interval(1'b0, 16'h0000, COORD_MAX);
    send_interval(1'b1, 16'h0000, COORD_MAX);
    send_interval(1'b0, 16'h7FFF, 16'h8000);
    send_interval(1'b0, 16'h8000, 16'hFFFE);
    send_interval(1'b1, 16'hAAAA, 16'h5555);
    send_interval(1'b0, 16'h5555, 16'hAAAA);
    send_interval(1'b0, 16'h1234, 16'hEDCB);
  endtask

  // Fills the whole active set, offers two more that cannot be stored, then two at the top coordinate.
  task automatic test_full_set();
    send_interval(1'b1, 16'h0000, COORD_MAX);
    for (int i = 1; i < ACTIVE_DEPTH + 2; i++)
      send_interval(1'b0, 16'(i), COORD_MAX);
    send_interval(1'b0, COORD_MAX, 16'h0000);
    send_interval(1'b0, COORD_MAX, COORD_MAX);
  endtask

  // The sink holds off while intervals with many overlaps keep coming.
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    send_interval(1'b1, 16'h0000, COORD_MAX);
    for (int i = 1; i < 12; i++)
      send_interval(1'b0, 16'(i * 16), COORD_MAX);
  endtask

  // Mostly well-formed sweeps with random spans, plus some arbitrary noise.
  task automatic test_random_sweeps(input int n_items);
    int unsigned roll;
    int unsigned span;
    int          pos;
    int          top;
    logic        rs;
    pos = 0;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_interval(roll == 0, 16'($urandom), 16'($urandom));
      end else begin
        pos = pos + $urandom_range(0, 128);
        rs  = (roll < 11) || (pos > int'(COORD_MAX));
        if (rs) pos = $urandom_range(1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
        roll = $urandom_range(99);
        if (roll < 60)      span = $urandom_range(0, 255);
        else if (roll < 90) span = $urandom_range(256, 4095);
        else                span = $urandom_range(4096, 65535);
        top = pos + span;
        if (top > int'(COORD_MAX)) top = COORD_MAX;
        send_interval(rs, 16'(pos), 16'(top));
      end
    end
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.restart   = 1'b0;
    in_ch.start_pos = '0;
    in_ch.end_pos   = '0;
    out_ch.ready    = 1'b0;
    errors          = 0;
    hold_req        = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    src_idle_pct    = 6;
    snk_idle_pct    = 72;
    clear_spans();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_sweeps(110);

    src_idle_pct = 72;
    snk_idle_pct = 6;
    test_full_set();
    test_backpressure();
    test_random_sweeps(100);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_sweeps(100);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pair_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("interval_overlap_pair_emitter regression: pass");
    else
      $display("interval_overlap_pair_emitter regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/iop_pkg.sv
rtl/core/iop_if.sv
rtl/core/iop_queue.sv
rtl/core/iop_front.sv
rtl/core/iop_sweep.sv
rtl/core/interval_overlap_pair_emitter.sv
tb/sv/testbench.sv
